@@ design/fmf_pkg.sv @@
// Package for the 128-tap chirp matched FIR filter.
// Holds the sample, coefficient and accumulator types, the tap count and the coefficient table.
// No dependencies; every other design file depends on it.
package fmf_pkg;

    localparam int TAPS        = 128;
    localparam int COEFF_COUNT = 128;
    localparam int SAMPLE_W    = 8;
    localparam int COEFF_W     = 5;
    localparam int PROD_W      = SAMPLE_W + COEFF_W;
    localparam int ACC_W       = 16;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic signed [COEFF_W-1:0]  t_coeff;
    typedef logic signed [PROD_W-1:0]   t_prod;
    typedef logic signed [ACC_W-1:0]    t_acc;

    localparam t_coeff C_COEFF [0:COEFF_COUNT-1] = '{
        5'sd10,  5'sd11,  5'sd11,  5'sd8,   5'sd3,   -5'sd3,  -5'sd8,  -5'sd11,
        -5'sd11, -5'sd10, -5'sd10, -5'sd10, -5'sd10, -5'sd10, -5'sd10, -5'sd10,
        -5'sd10, -5'sd10, -5'sd10, -5'sd10, -5'sd10, -5'sd10, -5'sd10, -5'sd10,
        -5'sd10, -5'sd10, -5'sd10, -5'sd10, -5'sd10, -5'sd10, -5'sd10, -5'sd10,
        -5'sd10, -5'sd11, -5'sd11, -5'sd8,  -5'sd3,  5'sd3,   5'sd8,   5'sd11,
        5'sd11,  5'sd10,  5'sd10,  5'sd10,  5'sd10,  5'sd10,  5'sd10,  5'sd10,
        5'sd10,  5'sd11,  5'sd11,  5'sd8,   5'sd3,   -5'sd3,  -5'sd8,  -5'sd11,
        -5'sd11, -5'sd10, -5'sd10, -5'sd10, -5'sd10, -5'sd10, -5'sd10, -5'sd10,
        -5'sd10, -5'sd11, -5'sd11, -5'sd8,  -5'sd3,  5'sd3,   5'sd8,   5'sd11,
        5'sd11,  5'sd10,  5'sd10,  5'sd10,  5'sd10,  5'sd10,  5'sd10,  5'sd10,
        5'sd10,  5'sd11,  5'sd11,  5'sd8,   5'sd3,   -5'sd3,  -5'sd8,  -5'sd11,
        -5'sd11, -5'sd10, -5'sd10, -5'sd10, -5'sd10, -5'sd10, -5'sd10, -5'sd10,
        -5'sd10, -5'sd11, -5'sd11, -5'sd8,  -5'sd3,  5'sd3,   5'sd8,   5'sd11,
        5'sd11,  5'sd10,  5'sd10,  5'sd10,  5'sd10,  5'sd10,  5'sd10,  5'sd10,
        5'sd10,  5'sd10,  5'sd10,  5'sd10,  5'sd10,  5'sd10,  5'sd10,  5'sd10,
        5'sd10,  5'sd10,  5'sd10,  5'sd10,  5'sd10,  5'sd10,  5'sd10,  5'sd10
    };

endpackage

@@ design/fmf_sample_if.sv @@
// Stream interface that carries one input sample per transaction.
// Depends on fmf_pkg for the sample type.
interface fmf_sample_if;
    logic            valid;
    logic            ready;
    fmf_pkg::t_sample sample;

    modport source (output valid, output sample, input ready);
    modport sink (input valid, input sample, output ready);
endinterface

@@ design/fmf_result_if.sv @@
// Stream interface that carries one filter output per transaction.
// Depends on fmf_pkg for the accumulator type.
interface fmf_result_if;
    logic         valid;
    logic         ready;
    fmf_pkg::t_acc filtered_sample;

    modport source (output valid, output filtered_sample, input ready);
    modport sink (input valid, input filtered_sample, output ready);
endinterface

@@ design/fmf_tap_cell.sv @@
// One tap of the transposed-form FIR chain: multiplies the broadcast sample by its
// coefficient and adds the partial sum handed over by the next tap. Depends on fmf_pkg.
module fmf_tap_cell (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  fmf_pkg::t_sample i_sample,
    input  fmf_pkg::t_coeff  i_coeff,
    input  fmf_pkg::t_acc    i_psum,
    output fmf_pkg::t_acc    o_psum
);
    import fmf_pkg::*;

    t_prod w_prod;
    t_acc  n_psum;
    t_acc  r_psum;

    assign w_prod = i_sample * i_coeff;
    assign n_psum = i_psum + {{(ACC_W-PROD_W){w_prod[PROD_W-1]}}, w_prod};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_psum <= '0;
        end else if (i_en) begin
            r_psum <= n_psum;
        end
    end

    assign o_psum = r_psum;
endmodule

@@ design/fir_matched_filter_128tap_top.sv @@
// Top level of the 128-tap chirp matched FIR filter: a chain of tap cells with an
// output handshake stage. Depends on fmf_pkg, fmf_sample_if, fmf_result_if, fmf_tap_cell.
//
// Usage: samples arrive on i_sample_ch and filter outputs leave on o_result_ch, both
// valid/ready streams; a transaction happens at a rising edge with valid and ready high.
// Every accepted sample produces exactly one output, valid in the cycle after acceptance.
// The filter takes one sample per cycle unless the receiver stalls; the rate is set by the
// chain of tap cells, which all update together on each accepted sample, with the first
// cell's register serving as the output register.
// The output is the sum of coefficient k times the sample k steps back, wrapped to
// 16 bits. Reset clears every partial sum, which is the same as an all-zero history.
// When the receiver stalls, the pending output is held and no new sample is taken
// until that output has been accepted; a new sample is taken in the same cycle that
// the pending output leaves.
module fir_matched_filter_128tap_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    fmf_sample_if.sink    i_sample_ch,
    fmf_result_if.source  o_result_ch
);
    import fmf_pkg::*;

    logic w_accept;
    logic r_out_valid;
    t_acc w_psum [0:TAPS];

    assign i_sample_ch.ready = !r_out_valid || o_result_ch.ready;
    assign w_accept          = i_sample_ch.valid && i_sample_ch.ready;

    assign w_psum[TAPS] = '0;

    for (genvar g = 0; g < TAPS; g++) begin : g_tap
        fmf_tap_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_en     (w_accept),
            .i_sample (i_sample_ch.sample),
            .i_coeff  (C_COEFF[g]),
            .i_psum   (w_psum[g+1]),
            .o_psum   (w_psum[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (o_result_ch.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_result_ch.valid           = r_out_valid;
    assign o_result_ch.filtered_sample = w_psum[0];

`ifndef SYNTHESIS
    a_accept_gives_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> o_result_ch.valid)
        else $error("Accepted sample did not produce an output.");

    a_no_input_when_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_ch.valid && !o_result_ch.ready) |-> !i_sample_ch.ready)
        else $error("Sample taken while an output was stalled.");

    a_output_only_moves_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_accept |=> $stable(o_result_ch.filtered_sample))
        else $error("Output changed without a new sample.");

    a_reset_clears_output: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_result_ch.valid)
        else $error("Output valid after reset.");
`endif
endmodule
